// ===== rtl/canonical_huffman_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// Canonical Huffman table assertion macros
// Shared property wrappers for the concurrent checks of the table block.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_HUFFMAN_TABLE_TOP_MACROS_SVH
`define CANONICAL_HUFFMAN_TABLE_TOP_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define CHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while reset is high
`define CHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// Canonical Huffman table package
// Field widths, table limits, command and status codes, and the control
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cht_pkg;

   // table limits
   localparam int MAX_CODE_LEN = 16;
   localparam int SYMBOL_SPACE = 256;
   localparam int TOTAL_MAX    = 511;

   // field widths
   localparam int CMD_W    = 2;
   localparam int LEN_W    = 5;
   localparam int COUNT_W  = 8;
   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 16;
   localparam int STATUS_W = 2;

   // internal widths
   localparam int NEXT_W     = CODE_W + 1;
   localparam int LOADED_W   = 9;
   localparam int SUM_W      = 12;
   localparam int CNT_IDX_W  = $clog2(MAX_CODE_LEN);
   localparam int SYM_IDX_W  = $clog2(SYMBOL_SPACE);
   localparam int ENTRY_W    = CODE_W + LEN_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_COUNT  = 2'd0,
      CMD_LOAD_SYMBOL = 2'd1,
      CMD_LOOKUP      = 2'd2,
      CMD_CLEAR       = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_MISS    = 2'd1,
      STATUS_OVERRUN = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic do_count;
      logic sym_init;
      logic sym_step;
      logic sym_assign;
      logic sym_reject;
      logic look_read;
      logic look_take;
      logic clear;
      logic reply;
   } cht_ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic loaded_full;
      logic loaded_zero;
      logic left_zero;
      logic cur_at_max;
      logic out_free;
   } cht_stat_type;

endpackage

// ===== rtl/cht_channels.sv =====
// ----------------------------------------------------------------------------
// Canonical Huffman table channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface cht_req_intf import cht_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [LEN_W-1:0]    length_index;
   logic [COUNT_W-1:0]  count;
   logic [SYMBOL_W-1:0] symbol;

   modport source (output valid, cmd, length_index, count, symbol, input ready);
   modport sink   (input valid, cmd, length_index, count, symbol, output ready);
endinterface

interface cht_rsp_intf import cht_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   code;
   logic [LEN_W-1:0]    code_length;
   logic [STATUS_W-1:0] status;

   modport source (output valid, code, code_length, status, input ready);
   modport sink   (input valid, code, code_length, status, output ready);
endinterface

// ===== rtl/cht_ctrl.sv =====
// ----------------------------------------------------------------------------
// Canonical Huffman table controller
// Sequences one command at a time: count load, symbol load with the length
// skip walk, lookup through the code store, clear, and the reply transfer.
// ----------------------------------------------------------------------------
module cht_ctrl import cht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             req_ready,
   input  cht_stat_type     stat,
   output cht_ctrl_type     ctrl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_COUNT,
      S_SYM_CHECK,
      S_SYM_SKIP,
      S_LOOK_READ,
      S_LOOK_TAKE,
      S_CLEAR,
      S_REPLY
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;
   logic      fire;

   assign req_ready = ready_ff;
   assign fire      = req_valid && ready_ff;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      ctrl.capture = fire;
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               unique case (cmd_type'(req_cmd))
                  CMD_LOAD_COUNT:  state_in = S_COUNT;
                  CMD_LOAD_SYMBOL: state_in = S_SYM_CHECK;
                  CMD_LOOKUP:      state_in = S_LOOK_READ;
                  CMD_CLEAR:       state_in = S_CLEAR;
               endcase
            end
         end
         S_COUNT: begin
            ctrl.do_count = 1'b1;
            state_in      = S_REPLY;
         end
         S_SYM_CHECK: begin
            priority if (stat.loaded_full) begin
               ctrl.sym_reject = 1'b1;
               state_in        = S_REPLY;
            end else if (stat.loaded_zero) begin
               ctrl.sym_init = 1'b1;
               state_in      = S_SYM_SKIP;
            end else begin
               state_in = S_SYM_SKIP;
            end
         end
         S_SYM_SKIP: begin
            // walk one length per cycle until a free code turns up or the last length runs out
            priority if (stat.left_zero && !stat.cur_at_max) begin
               ctrl.sym_step = 1'b1;
            end else if (stat.left_zero) begin
               ctrl.sym_reject = 1'b1;
               state_in        = S_REPLY;
            end else begin
               ctrl.sym_assign = 1'b1;
               state_in        = S_REPLY;
            end
         end
         S_LOOK_READ: begin
            ctrl.look_read = 1'b1;
            state_in       = S_LOOK_TAKE;
         end
         S_LOOK_TAKE: begin
            ctrl.look_take = 1'b1;
            state_in       = S_REPLY;
         end
         S_CLEAR: begin
            ctrl.clear = 1'b1;
            state_in   = S_REPLY;
         end
         S_REPLY: begin
            if (stat.out_free) begin
               ctrl.reply = 1'b1;
               state_in   = S_IDLE;
            end
         end
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

// ===== rtl/cht_dpath.sv =====
// ----------------------------------------------------------------------------
// Canonical Huffman table datapath
// Length counts, code generator registers, valid bits, the code store
// memory, the result holding register and the response output register.
// ----------------------------------------------------------------------------
module cht_dpath import cht_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cht_ctrl_type        ctrl,
   output cht_stat_type        stat,
   input  logic [LEN_W-1:0]    req_length_index,
   input  logic [COUNT_W-1:0]  req_count,
   input  logic [SYMBOL_W-1:0] req_symbol,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CODE_W-1:0]   rsp_code,
   output logic [LEN_W-1:0]    rsp_code_length,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam logic [SYMBOL_W:0] SYM_LIMIT = (SYMBOL_W + 1)'(SYMBOL_SPACE);

   // captured request
   logic [LEN_W-1:0]    idx_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [SYMBOL_W-1:0] sym_ff;

   // table state
   logic [COUNT_W-1:0]      counts_ff [MAX_CODE_LEN];
   logic [COUNT_W-1:0]      counts_in [MAX_CODE_LEN];
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [LEN_W-1:0]        cur_ff, cur_in;
   logic [COUNT_W-1:0]      left_ff, left_in;
   logic [NEXT_W-1:0]       next_ff, next_in;
   logic [LOADED_W-1:0]     loaded_ff, loaded_in;
   logic [SYMBOL_SPACE-1:0] valid_ff, valid_in;

   // code store
   logic [ENTRY_W-1:0] store_mem [SYMBOL_SPACE];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               hit_ff;

   // result and response
   logic [CODE_W-1:0] res_code_ff;
   logic [LEN_W-1:0]  res_len_ff;
   status_type        res_status_ff;
   logic              rsp_valid_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   status_type        rsp_status_ff;

   logic [LEN_W-1:0]     idx_m1;
   logic [CNT_IDX_W-1:0] cnt_wr_idx;
   logic                 idx_ok;
   logic [SYM_IDX_W-1:0] sym_idx;
   logic                 sym_in_space;
   logic [LOADED_W-1:0]  total_sat;
   logic                 mem_we;

   assign idx_m1       = idx_ff - LEN_W'(1);
   assign cnt_wr_idx   = idx_m1[CNT_IDX_W-1:0];
   assign idx_ok       = (idx_ff != '0) && (idx_ff <= LEN_W'(MAX_CODE_LEN));
   assign sym_idx      = sym_ff[SYM_IDX_W-1:0];
   assign sym_in_space = ({1'b0, sym_ff} < SYM_LIMIT);
   assign total_sat    = (sum_ff > SUM_W'(TOTAL_MAX)) ? LOADED_W'(TOTAL_MAX)
                                                      : sum_ff[LOADED_W-1:0];
   assign mem_we       = ctrl.sym_assign && sym_in_space && !valid_ff[sym_idx];

   assign stat.loaded_full = (loaded_ff >= total_sat);
   assign stat.loaded_zero = (loaded_ff == '0);
   assign stat.left_zero   = (left_ff == '0);
   assign stat.cur_at_max  = (cur_ff >= LEN_W'(MAX_CODE_LEN));
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   // hold the request payload for the length of the command
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         idx_ff <= req_length_index;
         cnt_ff <= req_count;
         sym_ff <= req_symbol;
      end
   end

   always_comb begin
      counts_in = counts_ff;
      sum_in    = sum_ff;
      cur_in    = cur_ff;
      left_in   = left_ff;
      next_in   = next_ff;
      loaded_in = loaded_ff;
      valid_in  = valid_ff;
      if (ctrl.clear) begin
         counts_in = '{default: '0};
         sum_in    = '0;
         cur_in    = LEN_W'(1);
         left_in   = '0;
         next_in   = '0;
         loaded_in = '0;
         valid_in  = '0;
      end
      if (ctrl.do_count && idx_ok) begin
         counts_in[cnt_wr_idx] = cnt_ff;
         sum_in = sum_ff - SUM_W'(counts_ff[cnt_wr_idx]) + SUM_W'(cnt_ff);
      end
      if (ctrl.sym_init) begin
         cur_in  = LEN_W'(1);
         next_in = '0;
         left_in = counts_ff[0];
      end
      if (ctrl.sym_step) begin
         // advance one length: shift the code, take that length's count
         cur_in  = cur_ff + LEN_W'(1);
         next_in = {next_ff[NEXT_W-2:0], 1'b0};
         left_in = counts_ff[cur_ff[CNT_IDX_W-1:0]];
      end
      if (ctrl.sym_assign) begin
         if (mem_we) begin
            valid_in[sym_idx] = 1'b1;
         end
         next_in   = next_ff + NEXT_W'(1);
         left_in   = left_ff - COUNT_W'(1);
         loaded_in = loaded_ff + LOADED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff <= '{default: '0};
         sum_ff    <= '0;
         cur_ff    <= LEN_W'(1);
         left_ff   <= '0;
         next_ff   <= '0;
         loaded_ff <= '0;
         valid_ff  <= '0;
      end else begin
         counts_ff <= counts_in;
         sum_ff    <= sum_in;
         cur_ff    <= cur_in;
         left_ff   <= left_in;
         next_ff   <= next_in;
         loaded_ff <= loaded_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[sym_idx] <= {next_ff[CODE_W-1:0], cur_ff};
      end
      if (ctrl.look_read) begin
         rd_data_ff <= store_mem[sym_idx];
         hit_ff     <= sym_in_space && valid_ff[sym_idx];
      end
   end

   // result of the command in flight
   always_ff @(posedge clock) begin
      if (ctrl.look_take) begin
         if (hit_ff) begin
            res_code_ff   <= rd_data_ff[ENTRY_W-1:LEN_W];
            res_len_ff    <= rd_data_ff[LEN_W-1:0];
            res_status_ff <= STATUS_OK;
         end else begin
            res_code_ff   <= '0;
            res_len_ff    <= '0;
            res_status_ff <= STATUS_MISS;
         end
      end else if (ctrl.sym_reject) begin
         res_code_ff   <= '0;
         res_len_ff    <= '0;
         res_status_ff <= STATUS_OVERRUN;
      end else if (ctrl.do_count || ctrl.sym_assign || ctrl.clear) begin
         res_code_ff   <= '0;
         res_len_ff    <= '0;
         res_status_ff <= STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.reply) begin
         rsp_code_ff   <= res_code_ff;
         rsp_len_ff    <= res_len_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code        = rsp_code_ff;
   assign rsp_code_length = rsp_len_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== rtl/canonical_huffman_table_top.sv =====
// Steps: a count load or a clear passes through its own step to the reply step; a lookup
//   reads the code store, then takes the result; a symbol load is refused at the check on a
//   full table, else skips over empty lengths and then assigns a code or refuses the load.
// One command at a time: a new request is taken only after the reply is registered.
// A stalled reply holds the controller in its reply step. Reset: synchronous, active high;
//   counts, valid bits and generator state clear at once, the code store is not cleared.
// ----------------------------------------------------------------------------
// Canonical Huffman table top level
// Builds the canonical code table from per-length counts and symbols and
// answers symbol lookups with code and code length.
// ----------------------------------------------------------------------------
`include "canonical_huffman_table_top_macros.svh"

module canonical_huffman_table_top import cht_pkg::*; (
   input logic         clock,
   input logic         reset,
   cht_req_intf.sink   req_ch,
   cht_rsp_intf.source rsp_ch
);

   // Command and status bundles between the two halves. The controller owns
   // sequencing only; every piece of table state sits in the datapath.
   cht_ctrl_type ctrl;
   cht_stat_type stat;

   // Controller: takes one request transfer, walks the command through its
   // steps (including the one-length-per-cycle skip over empty lengths while
   // loading a symbol) and holds in the reply step until the output register
   // is free or being drained in the same cycle.
   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // Datapath: count table with running total, code generator registers,
   // valid bit per symbol, the code store memory with registered read, and
   // the response register that separates us from the downstream stall.
   cht_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_length_index (req_ch.length_index),
      .req_count        (req_ch.count),
      .req_symbol       (req_ch.symbol),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_code         (rsp_ch.code),
      .rsp_code_length  (rsp_ch.code_length),
      .rsp_status       (rsp_ch.status)
   );

   // After a request transfer the controller is busy: drop ready next cycle.
   `CHT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_ch.valid && req_ch.ready,
                    !req_ch.ready, "request taken while a command is in flight")

   // Any non-ok answer carries no code bits.
   `CHT_ASSERT_NOW(a_fail_zero, clock, reset, rsp_ch.valid && (rsp_ch.status != STATUS_OK),
                   (rsp_ch.code == '0) && (rsp_ch.code_length == '0),
                   "failed reply carries code bits")

   // Stored lengths never exceed the longest code, and status stays a known code.
   `CHT_ASSERT_NOW(a_len_range, clock, reset, rsp_ch.valid,
                   (rsp_ch.code_length <= LEN_W'(MAX_CODE_LEN)) &&
                   (rsp_ch.status <= STATUS_OVERRUN),
                   "reply length or status out of range")

endmodule
